// ----- rtl/hcbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcbp_pkg
// shared types and constants for the prefix code bit packer
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

    localparam int unsigned BYTE_BITS      = 8;
    localparam int unsigned CODE_WORD_BITS = 32;
    localparam int unsigned LEN_W          = 6;   // code length field, 0 to 32
    localparam int unsigned CNT_W          = 3;   // leftover bit count, 0 to 7
    localparam int unsigned SHAMT_W        = 6;   // shift amount, 0 to 32

    // item kind carried on the input tuser
    typedef enum logic [1:0] {
        OP_ENCODE = 2'd0,
        OP_LOAD   = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_READ  = 3'd1,
        S_ALIGN = 3'd2,
        S_STEP  = 3'd3,
        S_FLUSH = 3'd4
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/huffman_code_bit_packer_core.sv -----
// sequencing: load or empty flush stays idle, flush with leftover bits enters flush; encode
//   goes read, align, then one step per output byte plus a closing step unless the last
//   byte ends the code; a step or flush waits while the output holds back a byte
// throughput: one item at a time, input not ready until done; one shared 32-bit shifter
//   aligns the code and drops the consumed bits
// reset: synchronous active low, clears sequencer, leftover bits and output valid only
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// prefix code table and msb-first bit packer with a byte stream output
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer_core #(
    parameter int unsigned NUM_SYMBOLS  = 256,
    parameter int unsigned MAX_CODE_LEN = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input stream
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
    input  wire  [47:0] i_s_axis_tdata,
    // [1:0] op
    input  wire  [1:0]  i_s_axis_tuser,
    // output stream
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [7:0] out_byte
    output logic [7:0]  o_m_axis_tdata,
    output logic        o_m_axis_tlast
);

    localparam int unsigned IDX_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int unsigned LEN_LIMIT =
        (MAX_CODE_LEN > hcbp_pkg::CODE_WORD_BITS) ? hcbp_pkg::CODE_WORD_BITS : MAX_CODE_LEN;
    localparam int unsigned CW        = hcbp_pkg::CODE_WORD_BITS;
    localparam int unsigned LW        = hcbp_pkg::LEN_W;
    localparam int unsigned CNW       = hcbp_pkg::CNT_W;
    localparam int unsigned BB        = hcbp_pkg::BYTE_BITS;

    localparam logic [LW-1:0]                  LIM     = LW'(LEN_LIMIT);
    localparam logic [8:0]                     NSYM    = 9'(NUM_SYMBOLS);
    localparam logic [hcbp_pkg::SHAMT_W-1:0]   WORD_SH = hcbp_pkg::SHAMT_W'(CW);
    localparam logic [LW-1:0]                  BYTE_L  = LW'(BB);

    // input fields
    logic [7:0]       w_symbol;
    logic [CW-1:0]    w_code_bits;
    logic [LW-1:0]    w_code_length;
    hcbp_pkg::t_op    w_op;

    assign w_symbol      = i_s_axis_tdata[7:0];
    assign w_code_bits   = i_s_axis_tdata[39:8];
    assign w_code_length = i_s_axis_tdata[45:40];
    assign w_op          = hcbp_pkg::t_op'(i_s_axis_tuser);

    // state
    hcbp_pkg::t_state r_state, n_state;
    logic [BB-1:0]    r_acc, n_acc;     // leftover bits, left aligned, zero filled
    logic [CNW-1:0]   r_cnt, n_cnt;     // number of leftover bits
    logic [CW-1:0]    r_code;           // remaining code bits, left aligned
    logic [LW-1:0]    r_rem;            // number of remaining code bits
    logic [IDX_W-1:0] r_sym;
    logic             r_out_valid;
    logic [BB-1:0]    r_out_byte;
    logic             r_out_last;

    // control from the sequencer
    logic                          w_accept;
    logic                          w_slot_free;
    logic                          w_sym_ok;
    logic                          w_mem_we;
    logic                          w_mem_re;
    logic                          w_load_code;
    logic                          w_emit;
    logic [BB-1:0]                 w_emit_byte;
    logic                          w_emit_last;
    logic [CW-1:0]                 w_sh_in;
    logic [hcbp_pkg::SHAMT_W-1:0]  w_sh_amt;
    logic [CW-1:0]                 w_sh_out;

    // step arithmetic
    logic [3:0]       w_need;           // bits that complete the current byte
    logic [LW-1:0]    w_sum;            // leftover plus remaining code bits
    logic             w_full;
    logic [LW-1:0]    w_rem_after;
    logic [BB-1:0]    w_merge;

    // table read data
    logic [LW+CW-1:0] w_rdata;
    logic [LW-1:0]    w_len_sat;

    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_sym_ok    = {1'b0, w_symbol} < NSYM;

    assign w_need      = 4'(BB) - {1'b0, r_cnt};
    assign w_sum       = LW'(r_cnt) + r_rem;
    assign w_full      = w_sum >= BYTE_L;
    assign w_rem_after = r_rem - LW'(w_need);
    // top code bits slide in right after the leftover bits
    assign w_merge     = r_acc | (r_code[CW-1 -: BB] >> r_cnt);

    // saturate the code length on load
    assign w_len_sat   = (w_code_length > LIM) ? LIM : w_code_length;

    hcbp_code_mem #(
        .DEPTH (NUM_SYMBOLS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_symbol[IDX_W-1:0]),
        .i_wdata ({w_len_sat, w_code_bits}),
        .i_re    (w_mem_re),
        .i_raddr (r_sym),
        .o_rdata (w_rdata)
    );

    hcbp_shift_unit u_shift (
        .i_data (w_sh_in),
        .i_amt  (w_sh_amt),
        .o_data (w_sh_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hcbp_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        hcbp_pkg::OP_ENCODE: begin
                            if (w_sym_ok) begin
                                n_state = hcbp_pkg::S_READ;
                            end
                        end
                        hcbp_pkg::OP_FLUSH: begin
                            if (r_cnt != '0) begin
                                n_state = hcbp_pkg::S_FLUSH;
                            end
                        end
                        default: n_state = hcbp_pkg::S_IDLE;
                    endcase
                end
            end
            hcbp_pkg::S_READ:  n_state = hcbp_pkg::S_ALIGN;
            hcbp_pkg::S_ALIGN: n_state = hcbp_pkg::S_STEP;
            hcbp_pkg::S_STEP: begin
                if (!w_full) begin
                    n_state = hcbp_pkg::S_IDLE;
                end else if (w_slot_free && (w_rem_after == '0)) begin
                    n_state = hcbp_pkg::S_IDLE;
                end
            end
            hcbp_pkg::S_FLUSH: begin
                if (w_slot_free) begin
                    n_state = hcbp_pkg::S_IDLE;
                end
            end
            default: n_state = hcbp_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_mem_we        = 1'b0;
        w_mem_re        = 1'b0;
        w_load_code     = 1'b0;
        w_emit          = 1'b0;
        w_emit_byte     = w_merge;
        w_emit_last     = 1'b0;
        w_sh_in         = r_code;
        w_sh_amt        = hcbp_pkg::SHAMT_W'(w_need);
        unique case (r_state)
            hcbp_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                w_mem_we = w_accept && (w_op == hcbp_pkg::OP_LOAD) && w_sym_ok;
            end
            hcbp_pkg::S_READ: begin
                w_mem_re = 1'b1;
            end
            hcbp_pkg::S_ALIGN: begin
                // left align the code in the word
                w_load_code = 1'b1;
                w_sh_in     = w_rdata[CW-1:0];
                w_sh_amt    = WORD_SH - hcbp_pkg::SHAMT_W'(w_rdata[LW+CW-1:CW]);
            end
            hcbp_pkg::S_STEP: begin
                w_emit      = w_full && w_slot_free;
                // no later byte when fewer than a byte of code is left
                w_emit_last = w_rem_after < BYTE_L;
            end
            hcbp_pkg::S_FLUSH: begin
                w_emit      = w_slot_free;
                w_emit_byte = r_acc;
                w_emit_last = 1'b1;
            end
            default: begin
                o_s_axis_tready = 1'b0;
            end
        endcase
    end

    // leftover bit update
    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (w_emit) begin
            n_acc = '0;
            n_cnt = '0;
        end else if ((r_state == hcbp_pkg::S_STEP) && !w_full) begin
            n_acc = w_merge;
            n_cnt = w_sum[CNW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hcbp_pkg::S_IDLE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sym <= w_symbol[IDX_W-1:0];
        end
        if (w_load_code) begin
            r_code <= w_sh_out;
            r_rem  <= w_rdata[LW+CW-1:CW];
        end else if (w_emit && (r_state == hcbp_pkg::S_STEP)) begin
            r_code <= w_sh_out;
            r_rem  <= w_rem_after;
        end
        if (w_emit) begin
            r_out_byte <= w_emit_byte;
            r_out_last <= w_emit_last;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_last;

`ifndef SYNTHESIS
    // leftover bits stay left aligned with zeros below them
    a_acc_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BB'(r_acc << r_cnt) == '0)
        else $error("leftover bits not zero filled");

    // remaining code bits stay left aligned with zeros below them
    a_code_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcbp_pkg::S_STEP) |-> (CW'(r_code << r_rem) == '0))
        else $error("remaining code bits not zero filled");

    // remaining code length never exceeds the length limit
    a_rem_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hcbp_pkg::S_STEP) |-> (r_rem <= LIM))
        else $error("remaining code length out of range");

    // a byte emitted by a step or a flush always clears the leftover count
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_cnt == '0))
        else $error("leftover count not cleared after byte");

    // a flush with leftover bits always goes on to the flush state
    a_flush_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == hcbp_pkg::OP_FLUSH) && (r_cnt != '0))
            |=> (r_state == hcbp_pkg::S_FLUSH))
        else $error("flush with leftover bits skipped");
`endif

endmodule

`default_nettype wire

// ----- rtl/hcbp_code_mem.sv -----
// ----------------------------------------------------------------------------
// hcbp_code_mem
// code table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_code_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
) (
    input  wire                                                   i_clk,
    input  wire                                                   i_we,
    input  wire  [AW-1:0]                                         i_waddr,
    input  wire  [hcbp_pkg::LEN_W+hcbp_pkg::CODE_WORD_BITS-1:0]   i_wdata,
    input  wire                                                   i_re,
    input  wire  [AW-1:0]                                         i_raddr,
    output logic [hcbp_pkg::LEN_W+hcbp_pkg::CODE_WORD_BITS-1:0]   o_rdata
);

    localparam int unsigned DW = hcbp_pkg::LEN_W + hcbp_pkg::CODE_WORD_BITS;

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/hcbp_shift_unit.sv -----
// ----------------------------------------------------------------------------
// hcbp_shift_unit
// shared left shifter for code alignment and dropping consumed code bits
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_shift_unit (
    input  wire  [hcbp_pkg::CODE_WORD_BITS-1:0] i_data,
    input  wire  [hcbp_pkg::SHAMT_W-1:0]        i_amt,
    output logic [hcbp_pkg::CODE_WORD_BITS-1:0] o_data
);

    localparam logic [hcbp_pkg::SHAMT_W-1:0] WORD =
        hcbp_pkg::SHAMT_W'(hcbp_pkg::CODE_WORD_BITS);

    // a shift by the full word width empties it
    always_comb begin
        if (i_amt >= WORD) begin
            o_data = '0;
        end else begin
            o_data = i_data << i_amt;
        end
    end

endmodule

`default_nettype wire
